>>> design/etd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_pkg: shared constants and types for the elapsed time digit display
// Field widths, time constants and the digit bundle passed to the output.
// ----------------------------------------------------------------------------
package etd_pkg;

	localparam int unsigned DefMsPerSecond = 1000;

	localparam int unsigned ValueW      = 32;  // seconds and millisecond counts
	localparam int unsigned Q60W        = 27;  // seconds / 60 for any 32-bit count
	localparam int unsigned HourW       = 21;  // seconds / 3600 for any 32-bit count
	localparam int unsigned HourDigitW  = 14;  // clamped hours, 0 to 9999
	localparam int unsigned SixtyW      = 6;   // minutes or seconds, 0 to 59

	localparam int unsigned SecPerMin   = 60;
	localparam int unsigned MinPerHour  = 60;
	localparam int unsigned Radix       = 10;

	localparam logic [HourDigitW-1:0] HourLimit = 14'd9999;

	typedef struct packed {
		logic [3:0] sec_ones;
		logic [2:0] sec_tens;
		logic [3:0] min_ones;
		logic [2:0] min_tens;
		logic [3:0] hr_ones;
		logic [3:0] hr_tens;
		logic [3:0] hr_hundreds;
		logic [3:0] hr_thousands;
		logic       hours_clamped;
	} etd_digits_t;

endpackage
`default_nettype wire

>>> design/etd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_in_if: refresh request channel
// Valid/ready channel carrying the reported seconds and the millisecond time.
// ----------------------------------------------------------------------------
interface etd_in_if import etd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ValueW-1:0] reported_seconds;
	logic [ValueW-1:0] now_ms;

	modport source (output valid, output reported_seconds, output now_ms, input ready);
	modport sink   (input valid, input reported_seconds, input now_ms, output ready);
endinterface
`default_nettype wire

>>> design/etd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_out_if: display digit channel
// Valid/ready channel carrying the eight display digits and the clamp flag.
// ----------------------------------------------------------------------------
interface etd_out_if import etd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [3:0] sec_ones;
	logic [2:0] sec_tens;
	logic [3:0] min_ones;
	logic [2:0] min_tens;
	logic [3:0] hr_ones;
	logic [3:0] hr_tens;
	logic [3:0] hr_hundreds;
	logic [3:0] hr_thousands;
	logic       hours_clamped;

	modport source (
		output valid, output sec_ones, output sec_tens, output min_ones, output min_tens,
		output hr_ones, output hr_tens, output hr_hundreds, output hr_thousands,
		output hours_clamped, input ready
	);
	modport sink (
		input valid, input sec_ones, input sec_tens, input min_ones, input min_tens,
		input hr_ones, input hr_tens, input hr_hundreds, input hr_thousands,
		input hours_clamped, output ready
	);
endinterface
`default_nettype wire

>>> design/elapsed_time_digit_display_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elapsed_time_digit_display_core: elapsed time display, HHHH.MM.SS
// Tracks a reported seconds count, extrapolates it between reports and emits
// eight decimal digits with saturated hours.
// ----------------------------------------------------------------------------
// One refresh request is taken every clock cycle while the display side does
// not stall. A request that rewrites the display yields one digit set; a
// request that leaves the display unchanged yields nothing. The rate is set
// by the report tracking loop, where the compare with the last report, the
// division of the elapsed milliseconds by MS_PER_SECOND, the saturating add
// and the compare with the shown value are all combinational. The digit split
// behind it is a three-stage pipeline and a registered output, so a stalled
// display side backs up through the stages before the refresh side stalls.
// ----------------------------------------------------------------------------
module elapsed_time_digit_display_core import etd_pkg::*; #(
	parameter int unsigned MS_PER_SECOND = DefMsPerSecond
) (
	input  logic      clk,
	input  logic      arst_n,
	etd_in_if.sink    refresh,
	etd_out_if.source display
);

	logic              val_valid;
	logic              val_ready;
	logic [ValueW-1:0] val_value;

	etd_tracker #(
		.MS_PER_SECOND (MS_PER_SECOND)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.refresh   (refresh),
		.val_valid (val_valid),
		.val_value (val_value),
		.val_ready (val_ready)
	);

	etd_splitter u_splitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.val_valid (val_valid),
		.val_value (val_value),
		.val_ready (val_ready),
		.display   (display)
	);

endmodule
`default_nettype wire

>>> design/etd_const_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_const_div: unsigned division by a constant
// Quotient by multiplication with a rounded-up reciprocal, exact for every
// WIDTH-bit dividend.
// ----------------------------------------------------------------------------
module etd_const_div import etd_pkg::*; #(
	parameter int unsigned WIDTH   = ValueW,
	parameter int unsigned DIVISOR = Radix
) (
	input  logic [WIDTH-1:0] x,
	output logic [WIDTH-1:0] q
);

	localparam int unsigned Shift = WIDTH + $clog2(DIVISOR);
	localparam logic [WIDTH:0] Magic = (WIDTH + 1)'(((64'd1 << Shift) / DIVISOR) + 64'd1);

	logic [2*WIDTH:0] prod;

	assign prod = {{(WIDTH + 1){1'b0}}, x} * {{WIDTH{1'b0}}, Magic};
	assign q    = WIDTH'(prod >> Shift);

endmodule
`default_nettype wire

>>> design/etd_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_tracker: report tracking and extrapolation
// Registers each refresh, compares it with the last report, extrapolates the
// seconds since that report and decides which value goes to the display.
// ----------------------------------------------------------------------------
module etd_tracker import etd_pkg::*; #(
	parameter int unsigned MS_PER_SECOND = DefMsPerSecond
) (
	input  logic              clk,
	input  logic              arst_n,
	etd_in_if.sink            refresh,
	output logic              val_valid,
	output logic [ValueW-1:0] val_value,
	input  logic              val_ready
);

	localparam int unsigned Divisor = (MS_PER_SECOND == 0) ? 1 : MS_PER_SECOND;

	logic              valid_s1;
	logic [ValueW-1:0] rep_s1;
	logic [ValueW-1:0] now_s1;

	logic              seen_q;
	logic [ValueW-1:0] last_q;
	logic [ValueW-1:0] shown_q;
	logic [ValueW-1:0] upd_q;

	logic              changed;
	logic              extend;
	logic              emit;
	logic              adv;
	logic [ValueW-1:0] diff;
	logic [ValueW-1:0] elapsed;
	logic [ValueW:0]   sum;
	logic [ValueW-1:0] total;

	etd_const_div #(
		.WIDTH   (ValueW),
		.DIVISOR (Divisor)
	) u_ms_div (
		.x (diff),
		.q (elapsed)
	);

	always_comb begin
		changed = !seen_q || (rep_s1 != last_q);
		diff    = now_s1 - upd_q;
		sum     = {1'b0, rep_s1} + {1'b0, elapsed};
		// saturate the extrapolated count
		total   = sum[ValueW] ? {ValueW{1'b1}} : sum[ValueW-1:0];
		extend  = (rep_s1 != '0) && (total > shown_q);
		emit    = changed || extend;
	end

	// a refresh that shows nothing leaves without waiting for the display side
	assign adv           = valid_s1 && (!emit || val_ready);
	assign refresh.ready = !valid_s1 || adv;
	assign val_valid     = valid_s1 && emit;
	assign val_value     = changed ? rep_s1 : total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (refresh.ready) begin
			valid_s1 <= refresh.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (refresh.ready && refresh.valid) begin
			rep_s1 <= refresh.reported_seconds;
			now_s1 <= refresh.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			last_q  <= '0;
			shown_q <= '0;
			upd_q   <= '0;
		end else if (adv) begin
			if (changed) begin
				seen_q  <= 1'b1;
				last_q  <= rep_s1;
				shown_q <= rep_s1;
				upd_q   <= now_s1;
			end else if (extend) begin
				shown_q <= total;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/etd_splitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_splitter: seconds to HHHH MM SS digits
// Three stages split a seconds count into hours, minutes and seconds, clamp
// the hours and form the decimal digits, followed by the output register.
// ----------------------------------------------------------------------------
module etd_splitter import etd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              val_valid,
	input  logic [ValueW-1:0] val_value,
	output logic              val_ready,
	etd_out_if.source         display
);

	// stage 2: seconds / 60
	logic              valid_s2;
	logic [ValueW-1:0] value_s2;
	logic [ValueW-1:0] q60_full;
	logic [ValueW-1:0] rem60;

	// stage 3: minutes count / 60
	logic              valid_s3;
	logic [Q60W-1:0]   q60_s3;
	logic [SixtyW-1:0] secs_s3;
	logic [Q60W-1:0]   hours_full;
	logic [Q60W-1:0]   rem_min;

	// stage 4: clamp and decimal digits
	logic                  valid_s4;
	logic [HourW-1:0]      hours_s4;
	logic [SixtyW-1:0]     mins_s4;
	logic [SixtyW-1:0]     secs_s4;
	logic [HourDigitW-1:0] hrs;
	logic                  clamp;
	logic [HourDigitW-1:0] h_d10;
	logic [HourDigitW-1:0] h_d100;
	logic [HourDigitW-1:0] h_d1000;
	logic [SixtyW-1:0]     s_d10;
	logic [SixtyW-1:0]     m_d10;
	etd_digits_t           digits;

	logic        out_valid_q;
	etd_digits_t digits_q;

	logic adv2, adv3, adv4;
	logic rdy3, rdy4;

	// ready ripples back from the output register
	assign adv4      = valid_s4 && (!out_valid_q || display.ready);
	assign rdy4      = !valid_s4 || adv4;
	assign adv3      = valid_s3 && rdy4;
	assign rdy3      = !valid_s3 || adv3;
	assign adv2      = valid_s2 && rdy3;
	assign val_ready = !valid_s2 || adv2;

	etd_const_div #(.WIDTH(ValueW), .DIVISOR(SecPerMin)) u_div_sec (
		.x (value_s2),
		.q (q60_full)
	);

	assign rem60 = value_s2 - q60_full * ValueW'(SecPerMin);

	etd_const_div #(.WIDTH(Q60W), .DIVISOR(MinPerHour)) u_div_min (
		.x (q60_s3),
		.q (hours_full)
	);

	assign rem_min = q60_s3 - hours_full * Q60W'(MinPerHour);

	always_comb begin
		clamp = hours_s4 > {{(HourW - HourDigitW){1'b0}}, HourLimit};
		hrs   = clamp ? HourLimit : hours_s4[HourDigitW-1:0];
	end

	etd_const_div #(.WIDTH(HourDigitW), .DIVISOR(Radix)) u_div_h10 (
		.x (hrs),
		.q (h_d10)
	);
	etd_const_div #(.WIDTH(HourDigitW), .DIVISOR(Radix * Radix)) u_div_h100 (
		.x (hrs),
		.q (h_d100)
	);
	etd_const_div #(.WIDTH(HourDigitW), .DIVISOR(Radix * Radix * Radix)) u_div_h1000 (
		.x (hrs),
		.q (h_d1000)
	);
	etd_const_div #(.WIDTH(SixtyW), .DIVISOR(Radix)) u_div_s10 (
		.x (secs_s4),
		.q (s_d10)
	);
	etd_const_div #(.WIDTH(SixtyW), .DIVISOR(Radix)) u_div_m10 (
		.x (mins_s4),
		.q (m_d10)
	);

	always_comb begin
		digits.sec_ones      = 4'(secs_s4 - s_d10 * SixtyW'(Radix));
		digits.sec_tens      = 3'(s_d10);
		digits.min_ones      = 4'(mins_s4 - m_d10 * SixtyW'(Radix));
		digits.min_tens      = 3'(m_d10);
		digits.hr_ones       = 4'(hrs - h_d10 * HourDigitW'(Radix));
		digits.hr_tens       = 4'(h_d10 - h_d100 * HourDigitW'(Radix));
		digits.hr_hundreds   = 4'(h_d100 - h_d1000 * HourDigitW'(Radix));
		digits.hr_thousands  = 4'(h_d1000);
		digits.hours_clamped = clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (val_ready) begin
				valid_s2 <= val_valid;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (adv4) begin
				out_valid_q <= 1'b1;
			end else if (display.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (val_ready && val_valid) begin
			value_s2 <= val_value;
		end
		if (adv2) begin
			q60_s3  <= q60_full[Q60W-1:0];
			secs_s3 <= rem60[SixtyW-1:0];
		end
		if (adv3) begin
			hours_s4 <= hours_full[HourW-1:0];
			mins_s4  <= rem_min[SixtyW-1:0];
			secs_s4  <= secs_s3;
		end
		if (adv4) begin
			digits_q <= digits;
		end
	end

	assign display.valid         = out_valid_q;
	assign display.sec_ones      = digits_q.sec_ones;
	assign display.sec_tens      = digits_q.sec_tens;
	assign display.min_ones      = digits_q.min_ones;
	assign display.min_tens      = digits_q.min_tens;
	assign display.hr_ones       = digits_q.hr_ones;
	assign display.hr_tens       = digits_q.hr_tens;
	assign display.hr_hundreds   = digits_q.hr_hundreds;
	assign display.hr_thousands  = digits_q.hr_thousands;
	assign display.hours_clamped = digits_q.hours_clamped;

endmodule
`default_nettype wire
